// ===== rtl/dtq_pkg.sv =====
// Shared types, codes and saturation helpers for the delta timer queue.
// Used by dtq_ctrl, dtq_datapath and delta_timer_queue_core; no dependencies.
package dtq_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2
  } dtq_cmd_code_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } dtq_status_e;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK_STEP,
    OP_WALK_STOP,
    OP_ASHIFT,
    OP_ANEW,
    OP_SCAN_STEP,
    OP_SCAN_HIT,
    OP_DSHIFT,
    OP_TICK,
    OP_FINISH
  } dtq_op_e;

  // Widths of the stream payloads
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned DELTA_W     = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned DUR_W       = 24;
  localparam int unsigned ELAPSED_W   = 16;

  // Walk remainder: a 24-bit duration plus up to 256 positive 32-bit deltas
  localparam int unsigned REM_W = 42;

  // One queue slot
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [ID_W-1:0]    id;
  } dtq_entry_t;

  // Controller to datapath and output stage
  typedef struct packed {
    dtq_op_e     op;
    logic        load_out;
    dtq_status_e status;
  } dtq_cmd_t;

  // Datapath flags back to the controller
  typedef struct packed {
    logic cnt_full;
    logic cnt_zero;
    logic walk_go;
    logic at_end;
    logic id_hit;
    logic ptr_eq_pos;
    logic next_in_list;
    logic ptr_eq_cnt;
    logic head_live;
    logic cnt_gt1;
  } dtq_stat_t;

  // Sign-extend a stored delta to the wide arithmetic width
  function automatic logic signed [REM_W-1:0] sext32(input logic [DELTA_W-1:0] v);
    return $signed({{(REM_W-DELTA_W){v[DELTA_W-1]}}, v});
  endfunction

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic [DELTA_W-1:0] sat32(input logic signed [REM_W-1:0] v);
    logic signed [REM_W-1:0] hi;
    logic signed [REM_W-1:0] lo;
    logic [DELTA_W-1:0]      r;
    hi = $signed({{(REM_W-DELTA_W+1){1'b0}}, {(DELTA_W-1){1'b1}}});
    lo = $signed({{(REM_W-DELTA_W+1){1'b1}}, {(DELTA_W-1){1'b0}}});
    if (v > hi) begin
      r = {1'b0, {(DELTA_W-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(DELTA_W-1){1'b0}}};
    end else begin
      r = v[DELTA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dtq_ctrl.sv =====
// Sequencer for the delta timer queue: walks add, delete and tick through
// the datapath one slot per cycle. Depends on dtq_pkg.
module dtq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  input  dtq_pkg::dtq_stat_t  stat_i,
  output dtq_pkg::dtq_cmd_t   cmd_o
);
  import dtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ASHIFT,
    S_ANEW,
    S_SCAN,
    S_DSHIFT,
    S_TICK,
    S_DONE
  } state_e;

  state_e      state_q, state_d;
  dtq_status_e status_q, status_d;
  dtq_op_e     op;
  logic        load_out;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state, datapath operation and result status
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    op       = OP_NONE;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op       = OP_LOAD;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (in_cmd_i)
            CMD_ADD: begin
              if (stat_i.cnt_full) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_WALK;
              end
            end
            CMD_DEL: begin
              if (stat_i.cnt_zero) begin
                status_d = ST_MISS;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_TICK: begin
              if (stat_i.cnt_zero) begin
                status_d = ST_MISS;
              end else begin
                state_d = S_TICK;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (stat_i.walk_go) begin
          op = OP_WALK_STEP;
        end else begin
          op      = OP_WALK_STOP;
          state_d = stat_i.at_end ? S_ANEW : S_ASHIFT;
        end
      end
      S_ASHIFT: begin
        op = OP_ASHIFT;
        if (stat_i.ptr_eq_pos) begin
          state_d = S_ANEW;
        end
      end
      S_ANEW: begin
        op       = OP_ANEW;
        status_d = ST_OK;
        state_d  = S_DONE;
      end
      S_SCAN: begin
        if (stat_i.at_end) begin
          status_d = ST_MISS;
          state_d  = S_DONE;
        end else if (stat_i.id_hit) begin
          op       = OP_SCAN_HIT;
          status_d = ST_OK;
          state_d  = stat_i.next_in_list ? S_DSHIFT : S_DONE;
        end else begin
          op = OP_SCAN_STEP;
        end
      end
      S_DSHIFT: begin
        op = OP_DSHIFT;
        if (stat_i.ptr_eq_cnt) begin
          state_d = S_DONE;
        end
      end
      S_TICK: begin
        op       = OP_TICK;
        status_d = ST_OK;
        if (stat_i.head_live || !stat_i.cnt_gt1) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DSHIFT;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          op       = OP_FINISH;
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the registered status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign cmd_o.op       = op;
  assign cmd_o.load_out = load_out;
  assign cmd_o.status   = status_q;

endmodule

// ===== rtl/dtq_datapath.sv =====
// Datapath of the delta timer queue: slot memory, walk pointer, remainder
// and carry arithmetic with saturation. Depends on dtq_pkg.
module dtq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtq_pkg::dtq_cmd_t             cmd_i,
  input  logic [dtq_pkg::ID_W-1:0]      item_id_i,
  input  logic [dtq_pkg::DUR_W-1:0]     duration_i,
  input  logic [dtq_pkg::ELAPSED_W-1:0] elapsed_i,
  output dtq_pkg::dtq_stat_t            stat_o,
  output logic                          expired_o,
  output logic [dtq_pkg::ID_W-1:0]      expired_id_o
);
  import dtq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Slot memory with registered read
  dtq_entry_t mem [QUEUE_DEPTH];
  dtq_entry_t rdata_q;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  dtq_entry_t wr_data;

  // Control registers
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  logic          first_q, first_d;

  // Payload registers
  logic signed [REM_W-1:0] rem_q, rem_d;
  logic [DELTA_W-1:0]      carry_q, carry_d;
  logic [ID_W-1:0]         id_q, id_d;
  logic [ELAPSED_W-1:0]    elapsed_q, elapsed_d;
  logic                    expired_q, expired_d;
  logic [ID_W-1:0]         exp_id_q, exp_id_d;

  logic signed [REM_W-1:0] rd_dx;
  logic [DELTA_W-1:0]      rem_sat;
  logic [DELTA_W-1:0]      ashift_delta;
  logic [DELTA_W-1:0]      dshift_delta;
  logic [DELTA_W-1:0]      tick_h;
  logic                    head_live;

  // Saturated arithmetic on the slot under the pointer
  assign rd_dx        = sext32(rdata_q.delta);
  assign rem_sat      = sat32(rem_q);
  assign ashift_delta = (ptr_q == pos_q) ? sat32(rd_dx - sext32(rem_sat)) : rdata_q.delta;
  assign dshift_delta = first_q ? sat32(rd_dx + sext32(carry_q)) : rdata_q.delta;
  assign tick_h       = sat32(rd_dx - $signed({{(REM_W-ELAPSED_W){1'b0}}, elapsed_q}));
  assign head_live    = ($signed(tick_h) > 0);

  // Decode the operation into register updates and at most one memory write
  always_comb begin
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    count_d   = count_q;
    first_d   = first_q;
    rem_d     = rem_q;
    carry_d   = carry_q;
    id_d      = id_q;
    elapsed_d = elapsed_q;
    expired_d = expired_q;
    exp_id_d  = exp_id_q;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rdata_q;
    case (cmd_i.op)
      OP_LOAD: begin
        id_d      = item_id_i;
        elapsed_d = elapsed_i;
        rem_d     = $signed({{(REM_W-DUR_W){1'b0}}, duration_i});
        expired_d = 1'b0;
        exp_id_d  = '0;
        ptr_d     = '0;
      end
      OP_WALK_STEP: begin
        rem_d = rem_q - rd_dx;
        ptr_d = ptr_q + CW'(1);
      end
      OP_WALK_STOP: begin
        pos_d = ptr_q;
        ptr_d = count_q - CW'(1);
      end
      OP_ASHIFT: begin
        // Move a slot up by one; the successor of the new entry gets shrunk
        wr_en   = 1'b1;
        wr_addr = AW'(ptr_q + CW'(1));
        wr_data = '{delta: ashift_delta, id: rdata_q.id};
        ptr_d   = ptr_q - CW'(1);
      end
      OP_ANEW: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos_q);
        wr_data = '{delta: rem_sat, id: id_q};
        count_d = count_q + CW'(1);
        ptr_d   = '0;
      end
      OP_SCAN_STEP: begin
        ptr_d = ptr_q + CW'(1);
      end
      OP_SCAN_HIT: begin
        pos_d   = ptr_q;
        carry_d = rdata_q.delta;
        first_d = 1'b1;
        ptr_d   = ptr_q + CW'(1);
        count_d = count_q - CW'(1);
      end
      OP_DSHIFT: begin
        // Move a slot down by one; the first one absorbs the removed delta
        wr_en   = 1'b1;
        wr_addr = AW'(ptr_q - CW'(1));
        wr_data = '{delta: dshift_delta, id: rdata_q.id};
        first_d = 1'b0;
        ptr_d   = ptr_q + CW'(1);
      end
      OP_TICK: begin
        if (head_live) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = '{delta: tick_h, id: rdata_q.id};
        end else begin
          expired_d = 1'b1;
          exp_id_d  = rdata_q.id;
          carry_d   = tick_h;
          pos_d     = '0;
          first_d   = 1'b1;
          ptr_d     = CW'(1);
          count_d   = count_q - CW'(1);
        end
      end
      OP_FINISH: begin
        ptr_d = '0;
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  // Write the slot memory, read ahead at the next pointer with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == AW'(ptr_d))) begin
      rdata_q <= wr_data;
    end else begin
      rdata_q <= mem[AW'(ptr_d)];
    end
  end

  // Hold control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      pos_q     <= '0;
      count_q   <= '0;
      first_q   <= 1'b0;
      expired_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      pos_q     <= pos_d;
      count_q   <= count_d;
      first_q   <= first_d;
      expired_q <= expired_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    carry_q   <= carry_d;
    id_q      <= id_d;
    elapsed_q <= elapsed_d;
    exp_id_q  <= exp_id_d;
  end

  // Flags for the controller
  assign stat_o.cnt_full     = (count_q == CW'(QUEUE_DEPTH));
  assign stat_o.cnt_zero     = (count_q == '0);
  assign stat_o.walk_go      = (ptr_q < count_q) && (rem_q > rd_dx);
  assign stat_o.at_end       = (ptr_q == count_q);
  assign stat_o.id_hit       = (rdata_q.id == id_q);
  assign stat_o.ptr_eq_pos   = (ptr_q == pos_q);
  assign stat_o.next_in_list = ((ptr_q + CW'(1)) < count_q);
  assign stat_o.ptr_eq_cnt   = (ptr_q == count_q);
  assign stat_o.head_live    = head_live;
  assign stat_o.cnt_gt1      = (count_q > CW'(1));

  assign expired_o    = expired_q;
  assign expired_id_o = exp_id_q;

endmodule

// ===== rtl/delta_timer_queue_core.sv =====
// Top level of the delta timer queue: controller, datapath and result register.
// Depends on dtq_pkg, dtq_ctrl and dtq_datapath.
//
// Usage: commands enter on the s_axis channel, one beat per command; the
// command code rides on s_axis_tuser, its arguments on s_axis_tdata. Every
// command returns exactly one result beat on m_axis (status, expired flag,
// expired id). Add inserts by expiry into a delta list, delete drops the first
// entry with a matching id, tick ages the head and expires at most one entry.
// The sequencer walks and shifts the slot memory one slot per cycle; a
// rejected add, a delete or tick on an empty queue and the unused code skip
// the walk and go straight to the result. The next command is accepted only
// after the result of the previous one loads. s_axis_tready is high only
// while no command is in flight; a new command is taken while the previous
// result still waits in the output register. If the receiver stalls, that
// result holds and the next command finishes its work and then waits for
// the register to free. Reset empties the queue (entry count to zero) at
// once; the slot memory is not cleared and needs no clearing pass.
module delta_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // item_id[15:0], duration[39:16], elapsed[55:40]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status[1:0], expired[2], expired_id[18:3], zero pad
);
  import dtq_pkg::*;

  dtq_cmd_t  cmd;
  dtq_stat_t stat;
  logic      out_free;
  logic      expired;
  logic [ID_W-1:0] expired_id;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign out_free = !out_valid_q || m_axis_tready;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_id_i    (s_axis_tdata[15:0]),
    .duration_i   (s_axis_tdata[39:16]),
    .elapsed_i    (s_axis_tdata[55:40]),
    .stat_o       (stat),
    .expired_o    (expired),
    .expired_id_o (expired_id)
  );

  // Result register: load a finished result, drop it once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      out_data_q <= {{(OUT_TDATA_W-ID_W-3){1'b0}}, expired_id, expired, cmd.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // One command in flight: an accepted beat closes the input at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a command is in flight");

  // An expired entry is only reported with status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[1:0] == ST_OK))
    else $error("expired flag with non-ok status");

  // Status always carries a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[1:0] == ST_OK) || (m_axis_tdata[1:0] == ST_MISS) ||
                       (m_axis_tdata[1:0] == ST_FULL)))
    else $error("undefined status code");

  // A result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !cmd.load_out)
    else $error("result register overwritten while stalled");

endmodule
